// ===== sv/vpa_pkg.sv =====
// vpa_pkg: shared types and constants for the variable partition allocator
// used by vpa_cell and variable_partition_allocator

package vpa_pkg;

  localparam int TableEntries = 16;
  localparam int IdxW = $clog2(TableEntries);
  localparam int CntW = IdxW + 1;

  localparam logic [1:0] POL_BEST  = 2'd0;
  localparam logic [1:0] POL_FIRST = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;
  localparam logic [1:0] POL_NEXT  = 2'd3;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NO_FIT   = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [1:0] REG_FIT_POLICY = 2'd0;

  typedef struct packed {
    logic [15:0] base;
    logic [15:0] last;
    logic [16:0] size;
    logic [7:0]  owner;
  } entry_t;

  localparam entry_t ENTRY_INIT = '{base: 16'h0000, last: 16'hFFFF,
                                    size: 17'h10000, owner: 8'h00};

  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_SPLIT,
    OP_MERGE1
  } cell_op_t;

  typedef struct packed {
    cell_op_t        op;
    logic            two;   // merge removes two entries
    logic [IdxW-1:0] at;
    entry_t          wa;
    entry_t          wb;
  } cell_ctl_t;

  typedef struct packed {
    logic        cmd;
    logic [16:0] alloc_size;
    logic [7:0]  owner_id;
    logic [15:0] next_from;
    logic [15:0] release_start;
  } vpa_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_start;
    logic [15:0] out_end;
    logic [16:0] out_size;
    logic [7:0]  out_owner;
    logic [4:0]  segments_in_use;
  } vpa_res_t;

endpackage

// ===== sv/vpa_cell.sv =====
// vpa_cell: one segment table entry, shifts with its neighbors on insert/remove
// depends on vpa_pkg

module vpa_cell import vpa_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic [IdxW-1:0] idx,
  input  cell_ctl_t       ctl,
  input  entry_t          from_left,
  input  entry_t          from_r1,
  input  entry_t          from_r2,
  output entry_t          ent
);

  logic [CntW-1:0] idx_w;
  logic [CntW-1:0] at_w;

  assign idx_w = {1'b0, idx};
  assign at_w  = {1'b0, ctl.at};

  always_ff @(posedge clk) begin
    if (rst) begin
      ent <= ENTRY_INIT;
    end else begin
      case (ctl.op)
        OP_WRITE: begin
          if (idx_w == at_w) ent <= ctl.wa;
        end
        OP_SPLIT: begin
          if (idx_w == at_w) ent <= ctl.wa;
          else if (idx_w == at_w + 1'b1) ent <= ctl.wb;
          else if (idx_w > at_w + 1'b1) ent <= from_left;
        end
        OP_MERGE1: begin
          if (idx_w == at_w) ent <= ctl.wa;
          else if (idx_w > at_w) ent <= ctl.two ? from_r2 : from_r1;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/variable_partition_allocator.sv =====
// variable_partition_allocator: top level, sequencer plus a row of table cells
// depends on vpa_pkg and vpa_cell
//
// usage: drive req and pulse start while busy is low; the transaction is taken
// at that edge and busy rises. The block scans the segment table one entry per
// cycle (every entry in use, 1 to 16), a release that finds its segment then
// reads its left and right neighbors, and an apply state updates the row of
// cells, inserting or removing entries by shifting the cells above the changed
// entry in parallel. The result is registered into res, with done high for
// exactly one cycle, in the cycle after the apply state. busy falls as done
// rises, so the next transaction can be taken at the edge that ends the result
// cycle. The receiver cannot stall: done is a single-cycle strobe.
// fit_policy is written over the apb port at byte address 0; write it only
// while idle, the block itself does not enforce this.
// Synchronous reset leaves one free segment spanning all of memory, a count of
// one and best-fit policy; no clearing pass is needed.

module variable_partition_allocator import vpa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  vpa_req_t    req,
  output logic        done,
  output vpa_res_t    res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_LEFT  = 5'b00100,
    S_RIGHT = 5'b01000,
    S_APPLY = 5'b10000
  } state_t;

  state_t          state;
  vpa_req_t        req_r;
  logic [1:0]      policy;
  logic [CntW-1:0] count;
  logic [IdxW-1:0] scan_idx;
  logic            found;
  logic [IdxW-1:0] pick_idx;
  entry_t          pick;
  entry_t          lent;
  entry_t          rent;

  entry_t          ents [TableEntries];
  entry_t          rd_entry;
  logic [IdxW-1:0] rd_idx;
  cell_ctl_t       ctl;

  // apb
  assign pready = 1'b1;
  assign prdata = (paddr == REG_FIT_POLICY) ? {30'b0, policy} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POL_BEST;
    end else if (psel && penable && pwrite && paddr == REG_FIT_POLICY) begin
      policy <= pwdata[1:0];
    end
  end

  // cell row
  for (genvar g = 0; g < TableEntries; g++) begin : g_cell
    entry_t left_n, r1_n, r2_n;
    if (g > 0) begin : g_l
      assign left_n = ents[g-1];
    end else begin : g_nl
      assign left_n = '0;
    end
    if (g + 1 < TableEntries) begin : g_r1
      assign r1_n = ents[g+1];
    end else begin : g_nr1
      assign r1_n = '0;
    end
    if (g + 2 < TableEntries) begin : g_r2
      assign r2_n = ents[g+2];
    end else begin : g_nr2
      assign r2_n = '0;
    end
    vpa_cell u_cell (
      .clk(clk), .rst(rst), .idx(IdxW'(g)), .ctl(ctl),
      .from_left(left_n), .from_r1(r1_n), .from_r2(r2_n), .ent(ents[g])
    );
  end

  always_comb begin
    unique case (state)
      S_LEFT:  rd_idx = pick_idx - 1'b1;
      S_RIGHT: rd_idx = pick_idx + 1'b1;
      default: rd_idx = scan_idx;
    endcase
  end
  assign rd_entry = ents[rd_idx];

  // scan qualifiers
  logic elig, better, matched, scan_last;
  always_comb begin
    elig = rd_entry.owner == 8'd0 && rd_entry.size >= req_r.alloc_size &&
           req_r.alloc_size != 17'd0 && req_r.owner_id != 8'd0 &&
           !(policy == POL_NEXT && rd_entry.base < req_r.next_from);
    case (policy)
      POL_BEST:  better = rd_entry.size < pick.size;
      POL_WORST: better = rd_entry.size > pick.size;
      default:   better = 1'b0;
    endcase
    matched   = rd_entry.base == req_r.release_start;
    scan_last = {1'b0, scan_idx} == count - 1'b1;
  end

  // apply decision
  logic            lfree, rfree;
  vpa_res_t        res_next;
  logic [CntW-1:0] count_next;
  logic [16:0]     front_last;
  always_comb begin
    ctl        = '{op: OP_NONE, two: 1'b0, at: pick_idx, wa: pick, wb: pick};
    res_next   = '0;
    count_next = count;
    lfree      = pick_idx != '0 && lent.owner == 8'd0;
    rfree      = ({1'b0, pick_idx} + 1'b1) < count && rent.owner == 8'd0;
    front_last = {1'b0, pick.base} + req_r.alloc_size - 17'd1;
    if (state == S_APPLY) begin
      if (req_r.cmd == CMD_ALLOC) begin
        if (!found) begin
          res_next.status = ST_NO_FIT;
        end else if (pick.size == req_r.alloc_size) begin
          ctl.op = OP_WRITE;
          ctl.wa.owner = req_r.owner_id;
          res_next = '{ST_DONE, pick.base, pick.last, pick.size, req_r.owner_id, 5'd0};
        end else if (count >= CntW'(TableEntries)) begin
          res_next.status = ST_FULL;
        end else begin
          ctl.op = OP_SPLIT;
          ctl.wa = '{base: pick.base, last: front_last[15:0],
                     size: req_r.alloc_size, owner: req_r.owner_id};
          ctl.wb = '{base: front_last[15:0] + 16'd1, last: pick.last,
                     size: pick.size - req_r.alloc_size, owner: 8'd0};
          count_next = count + 1'b1;
          res_next = '{ST_DONE, pick.base, front_last[15:0], req_r.alloc_size,
                       req_r.owner_id, 5'd0};
        end
      end else begin
        if (!found) begin
          res_next.status = ST_NOT_FOUND;
        end else begin
          ctl.op = OP_MERGE1;
          if (lfree && rfree) begin
            ctl.two = 1'b1;
            ctl.at  = pick_idx - 1'b1;
            ctl.wa  = '{base: lent.base, last: rent.last,
                        size: lent.size + pick.size + rent.size, owner: 8'd0};
            count_next = count - 2'd2;
          end else if (lfree) begin
            ctl.at = pick_idx - 1'b1;
            ctl.wa = '{base: lent.base, last: pick.last,
                       size: lent.size + pick.size, owner: 8'd0};
            count_next = count - 1'b1;
          end else if (rfree) begin
            ctl.wa = '{base: pick.base, last: rent.last,
                       size: pick.size + rent.size, owner: 8'd0};
            count_next = count - 1'b1;
          end else begin
            ctl.op = OP_WRITE;
            ctl.wa.owner = 8'd0;
          end
          res_next = '{ST_DONE, ctl.wa.base, ctl.wa.last, ctl.wa.size, 8'd0, 5'd0};
        end
      end
      res_next.segments_in_use = count_next;
    end
  end

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= CntW'(1);
      done  <= 1'b0;
      found <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req_r    <= req;
            scan_idx <= '0;
            found    <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (req_r.cmd == CMD_ALLOC) begin
            if (elig && (!found || better)) begin
              found    <= 1'b1;
              pick_idx <= scan_idx;
              pick     <= rd_entry;
            end
          end else if (matched && !found) begin
            found    <= 1'b1;
            pick_idx <= scan_idx;
            pick     <= rd_entry;
          end
          scan_idx <= scan_idx + 1'b1;
          if (scan_last) begin
            if (req_r.cmd == CMD_RELEASE && (found || matched)) state <= S_LEFT;
            else state <= S_APPLY;
          end
        end
        S_LEFT: begin
          lent  <= rd_entry;
          state <= S_RIGHT;
        end
        S_RIGHT: begin
          rent  <= rd_entry;
          state <= S_APPLY;
        end
        S_APPLY: begin
          res   <= res_next;
          count <= count_next;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
